@@ hw/rtl/wmqf_pkg.sv @@
`default_nettype none

package wmqf_pkg;

	// Window geometry
	localparam int MAX_WINDOW = 32;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

	localparam logic [7:0] GAP_BYTE = 8'h2D;

	// Register indexes
	typedef enum logic [1:0] {
		REG_WINDOW_SIZE    = 2'd0,
		REG_DIFF_QUAL_MIN  = 2'd1,
		REG_WIN_QUAL_MIN   = 2'd2,
		REG_WIN_MAX_MISM   = 2'd3
	} cfg_reg_t;

	localparam logic [5:0] WINDOW_SIZE_RST   = 6'd11;
	localparam logic [7:0] DIFF_QUAL_MIN_RST = 8'd30;
	localparam logic [7:0] WIN_QUAL_MIN_RST  = 8'd25;
	localparam logic [5:0] WIN_MAX_MISM_RST  = 6'd2;

	typedef struct packed {
		logic [7:0]  query_char;
		logic [7:0]  target_char;
		logic [7:0]  query_quality;
		logic        first_column;
		logic [31:0] target_start;
	} in_word_t;

	typedef struct packed {
		logic [31:0] target_position;
		logic [7:0]  target_base;
		logic [7:0]  query_base;
	} out_word_t;

	typedef struct packed {
		logic [5:0] window_size;
		logic [7:0] diff_quality_min;
		logic [7:0] window_quality_min;
		logic [5:0] window_max_mismatches;
	} cfg_t;

	// One upper-cased alignment column
	typedef struct packed {
		logic [7:0] q;
		logic [7:0] t;
		logic [7:0] qual;
	} column_t;

	// Running summary of the newest columns up to a cell
	typedef struct packed {
		logic [CNT_W-1:0] mism_cnt;
		logic [7:0]       min_qual;
		logic             gap;
	} prefix_t;

	localparam prefix_t PREFIX_EMPTY = '{mism_cnt: '0, min_qual: 8'hFF, gap: 1'b0};

	function automatic logic [7:0] upcase(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

	function automatic logic col_gap(input column_t c);
		return (c.q == GAP_BYTE) || (c.t == GAP_BYTE);
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wmqf_cell.sv @@
`default_nettype none

module wmqf_cell (
	input  wire logic             clk,
	input  wire logic             shift,
	input  wire wmqf_pkg::column_t new_col,
	input  wire wmqf_pkg::column_t prev_col,
	input  wire wmqf_pkg::prefix_t prev_pre,
	output wmqf_pkg::column_t     col,
	output wmqf_pkg::prefix_t     pre
);
	import wmqf_pkg::*;

	column_t col_q;
	prefix_t pre_q;
	prefix_t pre_d;

	// Fold the newest column into the neighbor's summary
	always_comb begin
		pre_d.mism_cnt = prev_pre.mism_cnt + CNT_W'(new_col.q != new_col.t);
		pre_d.min_qual = (new_col.qual < prev_pre.min_qual) ? new_col.qual : prev_pre.min_qual;
		pre_d.gap      = prev_pre.gap | col_gap(new_col);
	end

	// Advance one place down the chain on every accepted word
	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= prev_col;
			pre_q <= pre_d;
		end
	end

	assign col = col_q;
	assign pre = pre_q;

endmodule

`default_nettype wire

@@ hw/rtl/wmqf_judge.sv @@
`default_nettype none

module wmqf_judge (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire wmqf_pkg::cfg_t                                cfg,
	input  wire logic                                          valid,
	input  wire logic [wmqf_pkg::CNT_W-1:0]                    seen,
	input  wire logic [31:0]                                   pos,
	input  wire wmqf_pkg::column_t [wmqf_pkg::MAX_WINDOW-1:0]  cols,
	input  wire wmqf_pkg::prefix_t [wmqf_pkg::MAX_WINDOW-1:0]  pres,
	input  wire logic                                          out_ready,
	output logic                                               advance,
	output logic                                               out_valid,
	output wmqf_pkg::out_word_t                                out_word
);
	import wmqf_pkg::*;

	logic [6:0]       ws_ext;
	logic [CNT_W-1:0] w_eff;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] center;
	column_t          ce;
	prefix_t          lp;
	logic             center_ok;
	logic             win_ok;
	logic             hit;
	logic             out_valid_q;
	out_word_t        out_word_q;

	// Clamp window size into 1..MAX_WINDOW
	always_comb begin
		ws_ext = 7'(cfg.window_size);
		if (ws_ext == 7'd0) begin
			w_eff = CNT_W'(1);
		end else if (ws_ext > 7'(MAX_WINDOW)) begin
			w_eff = CNT_W'(MAX_WINDOW);
		end else begin
			w_eff = CNT_W'(ws_ext);
		end
		last_idx = IDX_W'(w_eff - CNT_W'(1));
		center   = IDX_W'(w_eff - CNT_W'(1) - (w_eff >> 1));
	end

	// Judge the center column and the whole window
	always_comb begin
		ce        = cols[center];
		lp        = pres[last_idx];
		center_ok = !col_gap(ce) && (ce.q != ce.t) && (ce.qual >= cfg.diff_quality_min);
		win_ok    = !lp.gap && (lp.min_qual >= cfg.window_quality_min)
			&& (7'(lp.mism_cnt) <= 7'(cfg.window_max_mismatches));
		hit       = valid && (seen >= w_eff) && center_ok && win_ok;
		advance   = !hit || !out_valid_q || out_ready;
	end

	// Output register: load a hit, drop the word once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (hit && advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && advance) begin
			out_word_q.target_position <= pos - 32'(center);
			out_word_q.target_base     <= ce.t;
			out_word_q.query_base      <= ce.q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

@@ hw/rtl/windowed_mismatch_quality_filter.sv @@
// An accepted column word is registered into the row of window cells, and a hit judged
// from the cell row is then registered into the output register. Throughput: one column
// word per cycle while in_ready is high; the row of window cells shifts once per accepted word.
// Input stalls only while a judged hit meets an untaken word in the output register.
// Reset (arst_n low, asynchronous) clears the column count, target counter,
// pipeline valids and loads the register defaults; cell contents are not cleared.
`default_nettype none

module windowed_mismatch_quality_filter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire wmqf_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output wmqf_pkg::out_word_t      out_word,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [7:0]          cfg_data
);
	import wmqf_pkg::*;

	cfg_t                         cfg_q;
	logic                         accept;
	logic                         advance;
	logic                         s1_v_q;
	logic [31:0]                  pos_s1;
	logic [CNT_W-1:0]             seen_q;
	logic [31:0]                  tcnt_q;
	logic [31:0]                  tbase;
	column_t                      new_col;
	column_t [MAX_WINDOW-1:0]     cols;
	prefix_t [MAX_WINDOW-1:0]     pres;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size           <= WINDOW_SIZE_RST;
			cfg_q.diff_quality_min      <= DIFF_QUAL_MIN_RST;
			cfg_q.window_quality_min    <= WIN_QUAL_MIN_RST;
			cfg_q.window_max_mismatches <= WIN_MAX_MISM_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_SIZE:   cfg_q.window_size           <= cfg_data[5:0];
				REG_DIFF_QUAL_MIN: cfg_q.diff_quality_min      <= cfg_data;
				REG_WIN_QUAL_MIN:  cfg_q.window_quality_min    <= cfg_data;
				REG_WIN_MAX_MISM:  cfg_q.window_max_mismatches <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Input handshake
	assign in_ready = !s1_v_q || advance;
	assign accept   = in_valid && in_ready;

	always_comb begin
		new_col.q    = upcase(in_word.query_char);
		new_col.t    = upcase(in_word.target_char);
		new_col.qual = in_word.query_quality;
		tbase        = in_word.first_column ? in_word.target_start : tcnt_q;
	end

	// Column count and target counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			seen_q <= '0;
			tcnt_q <= '0;
		end else begin
			s1_v_q <= accept || (s1_v_q && !advance);
			if (accept) begin
				if (in_word.first_column) begin
					seen_q <= CNT_W'(1);
				end else if (seen_q != CNT_W'(MAX_WINDOW)) begin
					seen_q <= seen_q + CNT_W'(1);
				end
				if (new_col.q == GAP_BYTE || new_col.t != GAP_BYTE) begin
					tcnt_q <= tbase + 32'd1;
				end else begin
					tcnt_q <= tbase;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= tbase;
		end
	end

	// Row of window cells, newest column in cell 0
	genvar gi;
	generate
		for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				wmqf_cell u_cell (
					.clk      (clk),
					.shift    (accept),
					.new_col  (new_col),
					.prev_col (new_col),
					.prev_pre (PREFIX_EMPTY),
					.col      (cols[gi]),
					.pre      (pres[gi])
				);
			end else begin : g_body
				wmqf_cell u_cell (
					.clk      (clk),
					.shift    (accept),
					.new_col  (new_col),
					.prev_col (cols[gi-1]),
					.prev_pre (pres[gi-1]),
					.col      (cols[gi]),
					.pre      (pres[gi])
				);
			end
		end
	endgenerate

	// Window judgment and output register
	wmqf_judge u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid     (s1_v_q),
		.seen      (seen_q),
		.pos       (pos_s1),
		.cols      (cols),
		.pres      (pres),
		.out_ready (out_ready),
		.advance   (advance),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

`ifndef NO_ASSERTIONS
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(MAX_WINDOW))
		else $error("column count above window depth");

	a_first_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_word.first_column |=> seen_q == CNT_W'(1))
		else $error("new alignment did not restart column count");

	a_out_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.query_base != out_word.target_base)
			&& (out_word.query_base != GAP_BYTE) && (out_word.target_base != GAP_BYTE))
		else $error("reported word is not a mismatch");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> s1_v_q && out_valid && !out_ready)
		else $error("input stalled without a waiting result");
`endif

endmodule

`default_nettype wire

@@ test/windowed_mismatch_quality_filter_checker.sv @@
module windowed_mismatch_quality_filter_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire wmqf_pkg::in_word_t  in_word,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire wmqf_pkg::out_word_t out_word,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [7:0]          cfg_data,
	output int                       errors,
	output int                       expected_left
);
	import wmqf_pkg::*;

	cfg_t        regs;
	column_t     recent [MAX_WINDOW];
	int unsigned seen_cols;
	logic [31:0] next_pos;
	out_word_t   pending_hits [$];
	int          fail_count = 0;

	assign errors = fail_count;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	function automatic void note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		fail_count++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endfunction

	// Shift one column word into the window and queue a report if the window qualifies
	task automatic take_column(input in_word_t w);
		column_t     col;
		column_t     mid_col;
		logic [31:0] pos;
		int          span;
		int          mid;
		int          mism;
		bit          clean;
		col.q    = fold_case(w.query_char);
		col.t    = fold_case(w.target_char);
		col.qual = w.query_quality;
		// restart counting on a new alignment
		if (w.first_column) begin
			seen_cols = 0;
			next_pos  = w.target_start;
		end
		pos = next_pos;
		// hold the target position on a target gap against a query base
		if (col.q == GAP_BYTE || col.t != GAP_BYTE) begin
			next_pos = next_pos + 32'd1;
		end
		for (int i = MAX_WINDOW - 1; i > 0; i--) begin
			recent[i] = recent[i - 1];
		end
		recent[0] = col;
		if (seen_cols < MAX_WINDOW) begin
			seen_cols++;
		end
		// clamp the window size into 1..MAX_WINDOW
		if (regs.window_size == 0) begin
			span = 1;
		end else if (int'(regs.window_size) > MAX_WINDOW) begin
			span = MAX_WINDOW;
		end else begin
			span = int'(regs.window_size);
		end
		if (seen_cols < span) begin
			return;
		end
		mid     = span - 1 - span / 2;
		mid_col = recent[mid];
		if (mid_col.q == GAP_BYTE || mid_col.t == GAP_BYTE || mid_col.q == mid_col.t) begin
			return;
		end
		if (mid_col.qual < regs.diff_quality_min) begin
			return;
		end
		// scan the window for gaps, low quality and mismatches
		mism  = 0;
		clean = 1'b1;
		for (int i = 0; i < span; i++) begin
			if (recent[i].qual < regs.window_quality_min || recent[i].q == GAP_BYTE
					|| recent[i].t == GAP_BYTE) begin
				clean = 1'b0;
			end else if (recent[i].q != recent[i].t) begin
				mism++;
			end
		end
		if (!clean || mism > int'(regs.window_max_mismatches)) begin
			return;
		end
		pending_hits.push_back(out_word_t'{target_position: pos - 32'(mid),
			target_base: mid_col.t, query_base: mid_col.q});
	endtask

	// Compare one result word with the oldest pending report
	task automatic check_result(input out_word_t got);
		out_word_t want;
		if (pending_hits.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected result, expected none, actual %h %h %h", $time,
				got.target_position, got.target_base, got.query_base);
			return;
		end
		want = pending_hits.pop_front();
		if (got.target_position !== want.target_position) begin
			note_mismatch("target_position", want.target_position, got.target_position);
		end
		if (got.target_base !== want.target_base) begin
			note_mismatch("target_base", 32'(want.target_base), 32'(got.target_base));
		end
		if (got.query_base !== want.query_base) begin
			note_mismatch("query_base", 32'(want.query_base), 32'(got.query_base));
		end
	endtask

	// Track register writes, accepted columns and result words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.window_size           = WINDOW_SIZE_RST;
			regs.diff_quality_min      = DIFF_QUAL_MIN_RST;
			regs.window_quality_min    = WIN_QUAL_MIN_RST;
			regs.window_max_mismatches = WIN_MAX_MISM_RST;
			seen_cols                  = 0;
			next_pos                   = '0;
			pending_hits.delete();
			expected_left <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_WINDOW_SIZE:   regs.window_size           = cfg_data[5:0];
					REG_DIFF_QUAL_MIN: regs.diff_quality_min      = cfg_data;
					REG_WIN_QUAL_MIN:  regs.window_quality_min    = cfg_data;
					REG_WIN_MAX_MISM:  regs.window_max_mismatches = cfg_data[5:0];
					default: ;
				endcase
			end
			// compare before queueing, a column never yields its word in the same cycle
			if (out_valid && out_ready) begin
				check_result(out_word);
			end
			if (in_valid && in_ready) begin
				take_column(in_word);
			end
			expected_left <= pending_hits.size();
		end
	end

endmodule

@@ test/tb_windowed_mismatch_quality_filter.sv @@
module tb_windowed_mismatch_quality_filter;
	import wmqf_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 175;
	localparam int HOLD_PHASE  = 0;
	localparam int HOLD_AFTER  = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 4;
	localparam int RUN_LIMIT   = 2_000_000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_word_t   in_word   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_word_t  out_word;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;

	int         errors;
	int         expected_left;
	int         phase_no     = -1;
	int         phase_items  = 0;
	bit         calm         = 1'b0;
	bit         held         = 1'b0;
	bit         rough        = 1'b0;
	int         mismatch_pct = 10;
	logic [7:0] qual_floor   = 8'd0;

	always #5 clk = ~clk;

	windowed_mismatch_quality_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	windowed_mismatch_quality_filter_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_word       (in_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_word      (out_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.expected_left (expected_left)
	);

	function automatic in_word_t make_column(input logic [7:0] q, input logic [7:0] t,
			input logic [7:0] qual, input bit first, input logic [31:0] start);
		in_word_t w;
		w.query_char    = q;
		w.target_char   = t;
		w.query_quality = qual;
		w.first_column  = first;
		w.target_start  = start;
		return w;
	endfunction

	function automatic logic [7:0] any_case(input logic [7:0] b);
		return $urandom_range(0, 1) ? (b | 8'h20) : b;
	endfunction

	// Build a column word: mostly clean bases, with gaps, low quality and noise mixed in
	function automatic in_word_t random_column(input bit starts);
		in_word_t   w;
		logic [7:0] bases [4];
		int         qi;
		int         ti;
		bases = '{8'h41, 8'h43, 8'h47, 8'h54};
		qi    = $urandom_range(0, 3);
		ti    = qi;
		if ($urandom_range(0, 99) < mismatch_pct) begin
			ti = (qi + $urandom_range(1, 3)) % 4;
		end
		w.query_char    = any_case(bases[qi]);
		w.target_char   = any_case(bases[ti]);
		w.query_quality = 8'($urandom_range(qual_floor, 255));
		w.first_column  = starts;
		w.target_start  = ($urandom_range(0, 99) < 20) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
			: $urandom;
		if ($urandom_range(0, 99) < (rough ? 20 : 1)) begin
			case ($urandom_range(0, 4))
				0: w.query_char = GAP_BYTE;
				1: w.target_char = GAP_BYTE;
				2: begin
					w.query_char  = GAP_BYTE;
					w.target_char = GAP_BYTE;
				end
				3: w.query_quality = 8'($urandom_range(0, qual_floor));
				default: begin
					w.query_char    = 8'($urandom);
					w.target_char   = 8'($urandom);
					w.query_quality = 8'($urandom);
					w.first_column  = 1'($urandom_range(0, 1));
				end
			endcase
		end
		return w;
	endfunction

	// Offer one column word and hold it until accepted
	task automatic send_column(input in_word_t w);
		bit taken;
		while (!calm && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		phase_items++;
	endtask

	// Drop valid, wait for every pending result, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// Offer one register word; valid stays high for the next one
	task automatic put_reg(input cfg_reg_t idx, input logic [7:0] data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic write_regs(input logic [7:0] ws, input logic [7:0] dq, input logic [7:0] wq,
			input logic [7:0] mm);
		put_reg(REG_WINDOW_SIZE, ws);
		put_reg(REG_DIFF_QUAL_MIN, dq);
		put_reg(REG_WIN_QUAL_MIN, wq);
		put_reg(REG_WIN_MAX_MISM, mm);
		cfg_valid  <= 1'b0;
		qual_floor = (dq > wq) ? dq : wq;
	endtask

	// Receiver: random stalls, one long hold-off to back the block up
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && phase_no == HOLD_PHASE && phase_items >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 16);
		end
	end

	// Stimulus
	initial begin
		logic [7:0] ws;
		logic [7:0] dq;
		logic [7:0] wq;
		logic [7:0] mm;
		int         len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: a reportable mismatch across the position wrap
		send_column(make_column(8'h41, 8'h61, 8'd25, 1'b1, 32'hFFFF_FFFA));
		send_column(make_column(8'h7A, 8'h5A, 8'd255, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h47, 8'h54, 8'd40, 1'b0, 32'hFFFF_FFFF));
		send_column(make_column(8'h00, 8'h00, 8'd25, 1'b0, 32'h0000_0000));
		send_column(make_column(8'hFF, 8'hFF, 8'd200, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h63, 8'h47, 8'd30, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h60, 8'h60, 8'd25, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h7B, 8'h7B, 8'd99, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h40, 8'h40, 8'd255, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h5B, 8'h5B, 8'd25, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h74, 8'h54, 8'd60, 1'b0, 32'h0000_0000));
		// target gap, query gap and double gap
		send_column(make_column(8'h41, GAP_BYTE, 8'd255, 1'b0, 32'h0000_0000));
		send_column(make_column(GAP_BYTE, 8'h43, 8'd0, 1'b0, 32'h0000_0000));
		send_column(make_column(GAP_BYTE, GAP_BYTE, 8'd255, 1'b0, 32'h0000_0000));
		// short alignment cut off by the next start
		send_column(make_column(8'h61, 8'h43, 8'd255, 1'b1, 32'h0000_0000));
		send_column(make_column(8'h43, 8'h63, 8'd255, 1'b0, 32'hFFFF_FFFF));
		send_column(make_column(8'h47, 8'h47, 8'd255, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h54, 8'h41, 8'd255, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h47, 8'h47, 8'd255, 1'b1, 32'hFFFF_FFFF));
		send_column(make_column(8'h80, 8'h81, 8'd128, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h41, 8'h41, 8'd127, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h7F, 8'h7F, 8'd1, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h55, 8'h75, 8'd254, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h62, 8'h42, 8'd31, 1'b0, 32'h0000_0000));
		send_column(make_column(8'h54, 8'h43, 8'd29, 1'b0, 32'h0000_0000));
		drain();

		// random phases, each under its own register settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin ws = 8'd1;   dq = 8'd0;   wq = 8'd0;   mm = 8'd1;   end
				1: begin ws = 8'd32;  dq = 8'd255; wq = 8'd255; mm = 8'd0;   end
				2: begin ws = 8'hC0;  dq = 8'd30;  wq = 8'd20;  mm = 8'd1;   end
				3: begin ws = 8'hFF;  dq = 8'd50;  wq = 8'd40;  mm = 8'h3F;  end
				4: begin ws = 8'd33;  dq = 8'd10;  wq = 8'd5;   mm = 8'd32;  end
				default: begin
					ws = 8'($urandom_range(0, 255));
					dq = 8'($urandom_range(0, 80));
					wq = 8'($urandom_range(0, 60));
					mm = 8'($urandom_range(0, 255));
				end
			endcase
			write_regs(ws, dq, wq, mm);
			phase_no    = p;
			phase_items = 0;
			calm        = (p == 2);
			while (phase_items < PHASE_ITEMS) begin
				rough        = ($urandom_range(0, 99) < 35);
				mismatch_pct = $urandom_range(3, 25);
				len          = $urandom_range(1, 70);
				for (int k = 0; k < len && phase_items < PHASE_ITEMS; k++) begin
					send_column(random_column(k == 0));
				end
			end
			calm = 1'b0;
			drain();
		end

		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(RUN_LIMIT);
		$display("Verification failed");
		$finish;
	end

endmodule
